[hw/rtl/lcfp_pkg.sv]
// Shared constants for the level context field parser.
package lcfp_pkg;

	localparam int CATEGORY_LIMIT_DEFAULT = 255;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LOWER_C = 8'h63;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic KIND_CATEGORY = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_TOO_SHORT = 3'd1;
	localparam logic [2:0] ST_COLONS = 3'd2;
	localparam logic [2:0] ST_BAD_TAIL = 3'd3;
	localparam logic [2:0] ST_RANGE = 3'd4;

	localparam logic [2:0] FIELD_FIRST = 3'd0;
	localparam logic [2:0] FIELD_SECOND = 3'd1;
	localparam logic [2:0] FIELD_CATS = 3'd2;
	localparam logic [2:0] FIELD_TAIL = 3'd3;
	localparam logic [2:0] FIELD_PAST = 3'd4;

endpackage

[hw/rtl/lcfp_char_if.sv]
// Character request channel and result channel interfaces.
interface lcfp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface lcfp_result_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [9:0] category_index;
	logic [3:0] type_digit;
	logic [3:0] value_digit;
	logic [6:0] tail_value;
	logic [2:0] status;

	modport source (
		output valid, output result_kind, output category_index, output type_digit,
		output value_digit, output tail_value, output status, input ready
	);
	modport sink (
		input valid, input result_kind, input category_index, input type_digit,
		input value_digit, input tail_value, input status, output ready
	);
endinterface

[hw/rtl/level_context_field_parser_unit.sv]
// Level context field parser: one character per cycle, category and summary results.
// Results are registered: a result enters the output register in the cycle after its character is accepted.
// Throughput: one character request per cycle; the request is held off only while
// an unread result sits in the output register and the sink is not ready.
// Reset: arst_n clears the parse state and the output valid flag at once; the output data registers are not reset.
// After the last character of a string all parse state returns to its reset values.
module level_context_field_parser_unit
	import lcfp_pkg::*;
#(
	parameter int CATEGORY_LIMIT = CATEGORY_LIMIT_DEFAULT
) (
	input logic          clk,
	input logic          arst_n,
	lcfp_char_if.sink    chars,
	lcfp_result_if.source results
);

	logic [2:0] field_q, field_n;
	logic [2:0] colon_q, colon_n;
	logic [2:0] tally_q, tally_n;
	logic [3:0] first_q, first_n;
	logic [3:0] second_q, second_n;
	logic [2:0] tok_len_q, tok_len_n;
	logic       tok_pfx_q, tok_pfx_n;
	logic       tok_seen_q, tok_seen_n;
	logic       tok_end_q, tok_end_n;
	logic [9:0] tok_num_q, tok_num_n;
	logic [9:0] prev_q, prev_n;
	logic [1:0] tail_len_q, tail_len_n;
	logic [6:0] tail_num_q, tail_num_n;
	logic       tail_ok_q, tail_ok_n;
	logic       fresh_q, fresh_n;

	logic        accept;
	logic        dig;
	logic [7:0]  diff;
	logic [3:0]  dval;
	logic        emit;
	logic [13:0] tok_mul;
	logic [10:0] tail_mul;
	logic        res_valid;
	logic        res_kind;
	logic [9:0]  res_cat;
	logic [3:0]  res_lt;
	logic [3:0]  res_lv;
	logic [6:0]  res_tail;
	logic [2:0]  res_st;

	logic        out_valid_q;
	logic        out_kind_q;
	logic [9:0]  out_cat_q;
	logic [3:0]  out_lt_q;
	logic [3:0]  out_lv_q;
	logic [6:0]  out_tail_q;
	logic [2:0]  out_st_q;

	assign chars.ready = !out_valid_q || results.ready;
	assign accept = chars.valid && chars.ready;

	always_comb begin
		dig = (chars.char_code >= CH_ZERO) && (chars.char_code <= CH_NINE);
		diff = chars.char_code - CH_ZERO;
		dval = diff[3:0];
		tok_mul = 14'(tok_num_q) * 14'd10 + 14'(dval);
		tail_mul = 11'(tail_num_q) * 11'd10 + 11'(dval);

		field_n = field_q;
		colon_n = colon_q;
		tally_n = tally_q;
		first_n = first_q;
		second_n = second_q;
		tok_len_n = tok_len_q;
		tok_pfx_n = tok_pfx_q;
		tok_seen_n = tok_seen_q;
		tok_end_n = tok_end_q;
		tok_num_n = tok_num_q;
		prev_n = prev_q;
		tail_len_n = tail_len_q;
		tail_num_n = tail_num_q;
		tail_ok_n = tail_ok_q;
		fresh_n = 1'b0;
		emit = 1'b0;

		if (tally_q < 3'd5) begin
			tally_n = tally_q + 3'd1;
		end

		if (fresh_q) begin
			if (field_q == FIELD_FIRST) begin
				first_n = dig ? dval : 4'd0;
			end else if (field_q == FIELD_SECOND) begin
				second_n = dig ? dval : 4'd0;
			end
		end

		if (chars.char_code == CH_COLON) begin
			if (colon_q < 3'd4) begin
				colon_n = colon_q + 3'd1;
			end
			if (field_q == FIELD_CATS && tok_len_q != 3'd0) begin
				emit = 1'b1;
			end
			if (field_q < FIELD_PAST) begin
				field_n = field_q + 3'd1;
			end
			fresh_n = 1'b1;
		end else if (field_q == FIELD_CATS) begin
			if (chars.char_code == CH_COMMA) begin
				emit = 1'b1;
			end else begin
				if (tok_len_q == 3'd0) begin
					tok_pfx_n = (chars.char_code == CH_LOWER_C);
				end else if (tok_len_q <= 3'd3 && tok_pfx_q && !tok_end_q) begin
					if (dig) begin
						tok_num_n = tok_mul[9:0];
						tok_seen_n = 1'b1;
					end else begin
						tok_end_n = 1'b1;
					end
				end
				if (tok_len_q < 3'd4) begin
					tok_len_n = tok_len_q + 3'd1;
				end
			end
		end else if (field_q == FIELD_TAIL) begin
			if (tail_len_q < 2'd2) begin
				if (dig) begin
					tail_num_n = tail_mul[6:0];
				end else begin
					tail_ok_n = 1'b0;
				end
			end
			if (tail_len_q < 2'd3) begin
				tail_len_n = tail_len_q + 2'd1;
			end
		end

		if (emit) begin
			if (tok_pfx_q && tok_seen_q) begin
				prev_n = tok_num_q;
			end
			tok_len_n = 3'd0;
			tok_pfx_n = 1'b0;
			tok_seen_n = 1'b0;
			tok_end_n = 1'b0;
			tok_num_n = 10'd0;
		end

		res_valid = chars.last_char || emit;
		res_kind = KIND_CATEGORY;
		res_cat = 10'd0;
		res_lt = 4'd0;
		res_lv = 4'd0;
		res_tail = 7'd0;
		res_st = ST_OK;
		if (chars.last_char) begin
			res_kind = KIND_SUMMARY;
			if (tally_n < 3'd5) begin
				res_st = ST_TOO_SHORT;
			end else if (colon_n != 3'd3) begin
				res_st = ST_COLONS;
			end else if (tail_len_n < 2'd1 || tail_len_n > 2'd2 || !tail_ok_n) begin
				res_st = ST_BAD_TAIL;
			end
			if (res_st == ST_OK) begin
				res_lt = first_n;
				res_lv = second_n;
				res_tail = tail_num_n;
			end
		end else begin
			res_cat = prev_n;
			if ({1'b0, prev_n} >= 11'(CATEGORY_LIMIT)) begin
				res_st = ST_RANGE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q <= FIELD_FIRST;
			colon_q <= 3'd0;
			tally_q <= 3'd0;
			first_q <= 4'd0;
			second_q <= 4'd0;
			tok_len_q <= 3'd0;
			tok_pfx_q <= 1'b0;
			tok_seen_q <= 1'b0;
			tok_end_q <= 1'b0;
			tok_num_q <= 10'd0;
			prev_q <= 10'd0;
			tail_len_q <= 2'd0;
			tail_num_q <= 7'd0;
			tail_ok_q <= 1'b1;
			fresh_q <= 1'b1;
		end else if (accept) begin
			if (chars.last_char) begin
				field_q <= FIELD_FIRST;
				colon_q <= 3'd0;
				tally_q <= 3'd0;
				first_q <= 4'd0;
				second_q <= 4'd0;
				tok_len_q <= 3'd0;
				tok_pfx_q <= 1'b0;
				tok_seen_q <= 1'b0;
				tok_end_q <= 1'b0;
				tok_num_q <= 10'd0;
				prev_q <= 10'd0;
				tail_len_q <= 2'd0;
				tail_num_q <= 7'd0;
				tail_ok_q <= 1'b1;
				fresh_q <= 1'b1;
			end else begin
				field_q <= field_n;
				colon_q <= colon_n;
				tally_q <= tally_n;
				first_q <= first_n;
				second_q <= second_n;
				tok_len_q <= tok_len_n;
				tok_pfx_q <= tok_pfx_n;
				tok_seen_q <= tok_seen_n;
				tok_end_q <= tok_end_n;
				tok_num_q <= tok_num_n;
				prev_q <= prev_n;
				tail_len_q <= tail_len_n;
				tail_num_q <= tail_num_n;
				tail_ok_q <= tail_ok_n;
				fresh_q <= fresh_n;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			out_kind_q <= res_kind;
			out_cat_q <= res_cat;
			out_lt_q <= res_lt;
			out_lv_q <= res_lv;
			out_tail_q <= res_tail;
			out_st_q <= res_st;
		end
	end

	assign results.valid = out_valid_q;
	assign results.result_kind = out_kind_q;
	assign results.category_index = out_cat_q;
	assign results.type_digit = out_lt_q;
	assign results.value_digit = out_lv_q;
	assign results.tail_value = out_tail_q;
	assign results.status = out_st_q;

endmodule

[hw/rtl/lcfp_checker.sv]
// Port-level checks for the level context field parser, bound to the parser unit.
module lcfp_checker
	import lcfp_pkg::*;
#(
	parameter int CATEGORY_LIMIT = CATEGORY_LIMIT_DEFAULT
) (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       result_kind,
	input logic [9:0] category_index,
	input logic [3:0] type_digit,
	input logic [3:0] value_digit,
	input logic [6:0] tail_value,
	input logic [2:0] status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(result_kind)
			&& $stable(category_index) && $stable(status) && $stable(tail_value))
		else $error("stalled result changed");

	a_cat_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result_kind == KIND_CATEGORY |->
			type_digit == 4'd0 && value_digit == 4'd0 && tail_value == 7'd0
			&& (status == ST_OK || status == ST_RANGE))
		else $error("category result carries summary fields");

	a_cat_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result_kind == KIND_CATEGORY |->
			(status == ST_RANGE) == ({1'b0, category_index} >= 11'(CATEGORY_LIMIT)))
		else $error("range flag disagrees with category index");

	a_sum_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result_kind == KIND_SUMMARY |->
			category_index == 10'd0 && status != ST_RANGE
			&& (status == ST_OK || (type_digit == 4'd0 && value_digit == 4'd0
				&& tail_value == 7'd0))
			&& type_digit <= 4'd9 && value_digit <= 4'd9 && tail_value <= 7'd99)
		else $error("malformed summary result");

endmodule

bind level_context_field_parser_unit lcfp_checker #(
	.CATEGORY_LIMIT(CATEGORY_LIMIT)
) u_lcfp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(results.valid),
	.res_ready(results.ready),
	.result_kind(results.result_kind),
	.category_index(results.category_index),
	.type_digit(results.type_digit),
	.value_digit(results.value_digit),
	.tail_value(results.tail_value),
	.status(results.status)
);

[tb/lcfp_result_checker.sv]
// Checker for the level context field parser: predicts every result and compares it.
module lcfp_result_checker
	import lcfp_pkg::*;
#(
	parameter int CATEGORY_LIMIT = CATEGORY_LIMIT_DEFAULT
) (
	input logic    clk,
	input logic    arst_n,
	lcfp_char_if   chars,
	lcfp_result_if results,
	output int     mismatches,
	output int     outstanding,
	output int     categories_seen,
	output int     summaries_seen
);

	typedef struct packed {
		logic       kind;
		logic [9:0] idx;
		logic [3:0] lvl_type;
		logic [3:0] lvl_value;
		logic [6:0] tail;
		logic [2:0] st;
	} parse_result_t;

	parse_result_t due_results[$];

	logic [2:0] field_no;
	logic [2:0] colons;
	logic [2:0] chars_seen;
	logic [3:0] lvl_type;
	logic [3:0] lvl_value;
	logic [2:0] tok_len;
	logic       tok_c;
	logic       tok_dig;
	logic       tok_end;
	logic [9:0] tok_num;
	logic [9:0] prev_cat;
	logic [1:0] tail_len;
	logic [6:0] tail_num;
	logic       tail_ok;
	logic       fresh;

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report($sformatf("%s got %0d, want %0d", name, got, want));
	endtask

	task automatic clear_token();
		tok_len = '0;
		tok_c = 1'b0;
		tok_dig = 1'b0;
		tok_end = 1'b0;
		tok_num = '0;
	endtask

	task automatic clear_parse();
		field_no = FIELD_FIRST;
		colons = '0;
		chars_seen = '0;
		lvl_type = '0;
		lvl_value = '0;
		clear_token();
		prev_cat = '0;
		tail_len = '0;
		tail_num = '0;
		tail_ok = 1'b1;
		fresh = 1'b1;
	endtask

	task automatic advance_parse(input logic [7:0] c, input logic last,
			output logic produced, output parse_result_t r);
		logic       dig;
		logic       close_tok;
		logic [2:0] st;
		dig = (c >= CH_ZERO) && (c <= CH_NINE);
		close_tok = 1'b0;
		produced = 1'b0;
		r = '0;
		if (chars_seen < 5)
			chars_seen++;
		if (fresh) begin
			if (field_no == FIELD_FIRST)
				lvl_type = dig ? 4'(c - CH_ZERO) : 4'd0;
			else if (field_no == FIELD_SECOND)
				lvl_value = dig ? 4'(c - CH_ZERO) : 4'd0;
		end
		fresh = 1'b0;
		if (c == CH_COLON) begin
			if (colons < 4)
				colons++;
			if (field_no == FIELD_CATS && tok_len != 0)
				close_tok = 1'b1;
			if (field_no < FIELD_PAST)
				field_no++;
			fresh = 1'b1;
		end else if (field_no == FIELD_CATS) begin
			if (c == CH_COMMA) begin
				close_tok = 1'b1;
			end else begin
				if (tok_len == 0) begin
					tok_c = (c == CH_LOWER_C);
				end else if (tok_len <= 3 && tok_c && !tok_end) begin
					if (dig) begin
						tok_num = 10'(tok_num * 10 + (c - CH_ZERO));
						tok_dig = 1'b1;
					end else begin
						tok_end = 1'b1;
					end
				end
				if (tok_len < 4)
					tok_len++;
			end
		end else if (field_no == FIELD_TAIL) begin
			if (tail_len < 2) begin
				if (dig)
					tail_num = 7'(tail_num * 10 + (c - CH_ZERO));
				else
					tail_ok = 1'b0;
			end
			if (tail_len < 3)
				tail_len++;
		end
		if (close_tok) begin
			if (tok_c && tok_dig)
				prev_cat = tok_num;
			clear_token();
		end
		if (last) begin
			st = ST_OK;
			if (chars_seen < 5)
				st = ST_TOO_SHORT;
			else if (colons != 3)
				st = ST_COLONS;
			else if (tail_len < 1 || tail_len > 2 || !tail_ok)
				st = ST_BAD_TAIL;
			produced = 1'b1;
			r.kind = KIND_SUMMARY;
			r.st = st;
			if (st == ST_OK) begin
				r.lvl_type = lvl_type;
				r.lvl_value = lvl_value;
				r.tail = tail_num;
			end
			clear_parse();
		end else if (close_tok) begin
			produced = 1'b1;
			r.kind = KIND_CATEGORY;
			r.idx = prev_cat;
			r.st = (prev_cat >= CATEGORY_LIMIT) ? ST_RANGE : ST_OK;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		parse_result_t want;
		parse_result_t got;
		logic          produced;
		if (!arst_n) begin
			clear_parse();
			due_results.delete();
			outstanding = 0;
		end else begin
			if (results.valid && results.ready) begin
				got.kind = results.result_kind;
				got.idx = results.category_index;
				got.lvl_type = results.type_digit;
				got.lvl_value = results.value_digit;
				got.tail = results.tail_value;
				got.st = results.status;
				if (got.kind == KIND_SUMMARY)
					summaries_seen++;
				else
					categories_seen++;
				if (due_results.size() == 0) begin
					report($sformatf("unexpected result kind %0d index %0d status %0d",
						got.kind, got.idx, got.st));
				end else begin
					want = due_results.pop_front();
					check_field("result_kind", got.kind, want.kind);
					check_field("category_index", got.idx, want.idx);
					check_field("type_digit", got.lvl_type, want.lvl_type);
					check_field("value_digit", got.lvl_value, want.lvl_value);
					check_field("tail_value", got.tail, want.tail);
					check_field("status", got.st, want.st);
				end
			end
			if (chars.valid && chars.ready) begin
				advance_parse(chars.char_code, chars.last_char, produced, want);
				if (produced)
					due_results.push_back(want);
			end
			outstanding = due_results.size();
		end
	end

endmodule

[tb/level_context_field_parser_unit_tb.sv]
// Testbench top for the level context field parser: clock, reset, character stimulus, verdict.
module level_context_field_parser_unit_tb;
	import lcfp_pkg::*;

	localparam int CAT_LIMIT = CATEGORY_LIMIT_DEFAULT;
	localparam int CHAR_TARGET = 850;
	localparam int QUIET_LIMIT = 1000;

	typedef enum int {INTACT, EXTRA_COLON, MISSING_COLON, BAD_TAIL, TRUNCATED} flaw_t;

	logic clk;
	logic arst_n;

	lcfp_char_if   chars();
	lcfp_result_if results();

	int mismatches;
	int outstanding;
	int categories_seen;
	int summaries_seen;
	int chars_sent;
	int strings_sent;

	logic [7:0] text[$];

	level_context_field_parser_unit #(
		.CATEGORY_LIMIT(CAT_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars),
		.results(results)
	);

	lcfp_result_checker #(
		.CATEGORY_LIMIT(CAT_LIMIT)
	) parse_checker (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars),
		.results(results),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.categories_seen(categories_seen),
		.summaries_seen(summaries_seen)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void put_byte(input logic [7:0] b);
		text.push_back(b);
	endfunction

	function automatic void put(input string s);
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
	endfunction

	function automatic void put_digit();
		put_byte(8'(CH_ZERO + $urandom_range(9)));
	endfunction

	// any byte that does not delimit a token
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == CH_COLON || b == CH_COMMA);
		return b;
	endfunction

	function automatic void put_level();
		case ($urandom_range(9))
			0: ;
			1: put_byte(8'($urandom_range(8'h3B, 8'h7E)));
			2: begin
				put_digit();
				put_digit();
			end
			default: put_digit();
		endcase
	endfunction

	function automatic void put_token();
		case ($urandom_range(11))
			0, 1: put($sformatf("c%0d", $urandom_range(9)));
			2: put($sformatf("c%0d", $urandom_range(10, 99)));
			3: put($sformatf("c%0d", $urandom_range(240, 270)));
			4: put($sformatf("c%0d", $urandom_range(999)));
			5: begin
				put($sformatf("c%0d", $urandom_range(99)));
				put_byte(plain_byte());
				put_digit();
			end
			6: put($sformatf("c%04d", $urandom_range(9999)));
			7: case ($urandom_range(5))
				0: put("c-1");
				1: put("c+7");
				2: put(" c3");
				3: put("c 4");
				4: put("-5");
				default: put(" ");
			endcase
			8: case ($urandom_range(3))
				0: put("c");
				1: put("cx9");
				2: put("x12");
				default: put("C5");
			endcase
			9: repeat ($urandom_range(1, 6)) put_byte(plain_byte());
			10: ;
			default: put($sformatf("c%0d", $urandom_range(100, 999)));
		endcase
	endfunction

	function automatic void build_string(input flaw_t flaw);
		int n;
		int keep;
		put_level();
		put(":");
		put_level();
		put(":");
		n = $urandom_range(4);
		for (int i = 0; i < n; i++) begin
			if (i != 0)
				put(",");
			put_token();
		end
		if (flaw != MISSING_COLON)
			put(":");
		if (flaw == BAD_TAIL) begin
			case ($urandom_range(4))
				0: ;
				1: put($sformatf("%0d", $urandom_range(100, 999)));
				2: put_byte(plain_byte());
				3: begin
					put_digit();
					put_byte(plain_byte());
				end
				default: begin
					put_digit();
					put(",");
					put_digit();
				end
			endcase
		end else if ($urandom_range(3) == 0) begin
			put($sformatf("%02d", $urandom_range(99)));
		end else begin
			put($sformatf("%0d", $urandom_range(99)));
		end
		if (flaw == EXTRA_COLON) begin
			put(":");
			repeat ($urandom_range(3)) put_byte(8'($urandom_range(255)));
		end
		if (flaw == TRUNCATED) begin
			keep = $urandom_range(1, 4);
			while (text.size() > keep)
				void'(text.pop_back());
		end
	endfunction

	function automatic void build_noise();
		repeat ($urandom_range(1, 12)) begin
			case ($urandom_range(7))
				0: put(":");
				1: put(",");
				default: put_byte(8'($urandom_range(255)));
			endcase
		end
	endfunction

	task automatic send_char(input logic [7:0] c, input logic fin);
		while (!(chars_sent >= 400 && chars_sent < 550) && $urandom_range(99) < 36) begin
			chars.valid <= 1'b0;
			@(negedge clk);
		end
		chars.valid <= 1'b1;
		chars.char_code <= c;
		chars.last_char <= fin;
		@(posedge clk);
		while (!chars.ready)
			@(posedge clk);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_text();
		for (int i = 0; i < text.size(); i++)
			send_char(text[i], i == text.size() - 1);
		strings_sent++;
		text.delete();
	endtask

	initial begin
		int pick;
		arst_n = 1'b0;
		chars.valid = 1'b0;
		chars.char_code = '0;
		chars.last_char = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// extreme digits, index past the limit, empty and signed tokens
		put("9:0:c999,,+:0");
		send_text();
		// empty leading field, final colon ending a token, empty tail
		put(":x:c:");
		send_text();
		put("1:");
		send_text();
		put_byte(8'hFF);
		send_text();

		while (chars_sent < CHAR_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 65)
				build_string(INTACT);
			else if (pick < 85)
				build_string(flaw_t'($urandom_range(EXTRA_COLON, TRUNCATED)));
			else
				build_noise();
			send_text();
		end
		chars.valid <= 1'b0;

		while (outstanding != 0)
			@(negedge clk);
		repeat (5) @(negedge clk);

		$display("sent %0d characters in %0d strings, with a long result stall", chars_sent,
			strings_sent);
		$display("checked %0d category and %0d summary results", categories_seen,
			summaries_seen);
		if (mismatches == 0)
			$display("level_context_field_parser_unit_tb: done, clean");
		else
			$display("level_context_field_parser_unit_tb: done, errors");
		$finish;
	end

	// result side: random holds, one long hold-off, then a stretch always ready
	initial begin
		int cyc;
		cyc = 0;
		results.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc >= 300 && cyc < 360)
				results.ready <= 1'b0;
			else if (cyc >= 700 && cyc < 1000)
				results.ready <= 1'b1;
			else
				results.ready <= ($urandom_range(99) >= 36);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((chars.valid && chars.ready) || (results.valid && results.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("level_context_field_parser_unit_tb: done, errors");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/lcfp_pkg.sv
hw/rtl/lcfp_char_if.sv
hw/rtl/level_context_field_parser_unit.sv
hw/rtl/lcfp_checker.sv
tb/lcfp_result_checker.sv
tb/level_context_field_parser_unit_tb.sv
